// ===== rtl/core/csbe_pkg.sv =====
// Package for the clock set-button editor: register indexes, field codes,
// reset values and the small increment functions for each time field.
// No dependencies.
package csbe_pkg;

  typedef enum logic [1:0] {
    CfgEnterHold    = 2'd0,
    CfgRepeatDelay  = 2'd1,
    CfgRepeatPeriod = 2'd2,
    CfgExitIdle     = 2'd3
  } cfg_idx_e;

  localparam int unsigned CfgDataW = 13;

  localparam logic [2:0] FieldSecond = 3'd0;
  localparam logic [2:0] FieldMinute = 3'd1;
  localparam logic [2:0] FieldHour   = 3'd2;
  localparam logic [2:0] FieldDay    = 3'd3;
  localparam logic [2:0] FieldMonth  = 3'd4;
  localparam logic [2:0] FieldYear   = 3'd5;

  localparam logic [11:0] EnterHoldReset    = 12'd800;
  localparam logic [11:0] RepeatDelayReset  = 12'd600;
  localparam logic [9:0]  RepeatPeriodReset = 10'd200;
  localparam logic [12:0] ExitIdleReset     = 13'd3000;

  localparam logic [11:0] PressMax   = 12'hFFF;
  localparam logic [12:0] ReleaseMax = 13'h1FFF;

  // Seconds and minutes count 0..59.
  function automatic logic [5:0] inc_mod60(input logic [5:0] v);
    logic [6:0] s;
    s = {1'b0, v} + 7'd1;
    if (s >= 7'd60) s = s - 7'd60;
    return s[5:0];
  endfunction

  function automatic logic [4:0] inc_hour(input logic [4:0] v);
    logic [5:0] s;
    s = {1'b0, v} + 6'd1;
    if (s >= 6'd24) s = s - 6'd24;
    return s[4:0];
  endfunction

  // Month length; an invalid month counts as 31 days.
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic [6:0] y);
    logic [4:0] len;
    len = 5'd31;
    if (m == 4'd4 || m == 4'd6 || m == 4'd9 || m == 4'd11) begin
      len = 5'd30;
    end else if (m == 4'd2) begin
      len = (y == 7'd20 || y == 7'd24 || y == 7'd28) ? 5'd29 : 5'd28;
    end
    return len;
  endfunction

  // Day count wraps to 1; a day above the month length folds back once.
  function automatic logic [4:0] inc_day(input logic [4:0] d, input logic [4:0] len);
    logic [5:0] s;
    s = {1'b0, d} + 6'd1;
    if (s >= {1'b0, len}) s = s - {1'b0, len};
    if (s == 6'd0) s = {1'b0, len};
    return s[4:0];
  endfunction

  function automatic logic [3:0] inc_month(input logic [3:0] m);
    logic [4:0] s;
    s = {1'b0, m} + 5'd1;
    if (s >= 5'd12) s = s - 5'd12;
    if (s == 5'd0) s = 5'd12;
    return s[3:0];
  endfunction

  // Years run 20..30; anything outside that range restarts at 20.
  function automatic logic [6:0] inc_year(input logic [6:0] y);
    logic [6:0] r;
    r = 7'd20;
    if (y >= 7'd20 && y < 7'd30) r = y + 7'd1;
    return r;
  endfunction

  function automatic logic [2:0] next_select(input logic [2:0] f);
    logic [3:0] s;
    s = {1'b0, f} + 4'd1;
    if (s >= 4'd6) s = s - 4'd6;
    return s[2:0];
  endfunction

endpackage

// ===== rtl/core/csbe_if.sv =====
// Stream interfaces of the clock set-button editor: tick input and result output.
// Each carries valid, ready and the payload fields. No dependencies.
interface csbe_in_if;
  logic       valid;
  logic       ready;
  logic       button_pressed;
  logic [5:0] clock_second;
  logic [5:0] clock_minute;
  logic [4:0] clock_hour;
  logic [4:0] clock_day;
  logic [3:0] clock_month;
  logic [6:0] clock_year;

  modport source (output valid, button_pressed, clock_second, clock_minute, clock_hour,
                  clock_day, clock_month, clock_year, input ready);
  modport sink (input valid, button_pressed, clock_second, clock_minute, clock_hour,
                clock_day, clock_month, clock_year, output ready);
endinterface

interface csbe_out_if;
  logic       valid;
  logic       ready;
  logic       editing;
  logic [2:0] selected_field;
  logic [5:0] out_second;
  logic [5:0] out_minute;
  logic [4:0] out_hour;
  logic [4:0] out_day;
  logic [3:0] out_month;
  logic [6:0] out_year;
  logic       commit;

  modport source (output valid, editing, selected_field, out_second, out_minute, out_hour,
                  out_day, out_month, out_year, commit, input ready);
  modport sink (input valid, editing, selected_field, out_second, out_minute, out_hour,
                out_day, out_month, out_year, commit, output ready);
endinterface

// ===== rtl/core/clock_set_button_editor.sv =====
// Top level of the clock set-button editor: button timing, edit state and time fields.
// Depends on csbe_pkg and the stream interfaces in csbe_if.
//
//   Channel   Dir   Payload                                   Handshake
//   in_i      in    button level, clock sec..year            valid/ready
//   out_o     out   editing, field, held sec..year, commit   valid/ready
//   cfg       in    index (2 bits), data (13 bits)           write enable only
//
// A new tick is taken in every cycle while the result register is empty or its
// result is being transferred.
// The state registers double as the result register, so a result always
// shows the state after its tick; commit is held beside them.
// When out_o stalls, in_i.ready drops and no state changes until the transfer.
// Reset loads register defaults, clears edit mode, counts and times, selects minute.
module clock_set_button_editor (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  csbe_in_if.sink                      in_i,
  csbe_out_if.source                   out_o,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [csbe_pkg::CfgDataW-1:0] cfg_wdata_i
);

  // Configuration registers.
  logic [11:0] enter_hold_q, repeat_delay_q;
  logic [9:0]  repeat_period_q;
  logic [12:0] exit_idle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enter_hold_q    <= csbe_pkg::EnterHoldReset;
      repeat_delay_q  <= csbe_pkg::RepeatDelayReset;
      repeat_period_q <= csbe_pkg::RepeatPeriodReset;
      exit_idle_q     <= csbe_pkg::ExitIdleReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        csbe_pkg::CfgEnterHold:    enter_hold_q    <= cfg_wdata_i[11:0];
        csbe_pkg::CfgRepeatDelay:  repeat_delay_q  <= cfg_wdata_i[11:0];
        csbe_pkg::CfgRepeatPeriod: repeat_period_q <= cfg_wdata_i[9:0];
        csbe_pkg::CfgExitIdle:     exit_idle_q     <= cfg_wdata_i[12:0];
        default: ;
      endcase
    end
  end

  // Edit state and the time fields; these are also the result payload.
  logic        edit_q, edit_d;
  logic [2:0]  sel_q, sel_d;
  logic [2:0]  pend_q, pend_d;
  logic [11:0] press_q, press_d;
  logic [12:0] rel_q, rel_d;
  logic [9:0]  phase_q, phase_d;
  logic [11:0] enter_q, enter_d;
  logic [5:0]  sec_q, sec_d, min_q, min_d;
  logic [4:0]  hour_q, hour_d, day_q, day_d;
  logic [3:0]  month_q, month_d;
  logic [6:0]  year_q, year_d;
  logic        commit_q, commit_d;
  logic        out_valid_q;

  logic        accept;
  logic        pressed;
  logic [10:0] phase_inc;
  logic [11:0] press_inc, enter_inc;
  logic [12:0] rel_inc;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign pressed    = in_i.button_pressed;

  // Saturating counts and the free-running repeat phase.
  assign phase_inc = {1'b0, phase_q} + 11'd1;
  assign press_inc = (press_q == csbe_pkg::PressMax) ? press_q : press_q + 12'd1;
  assign enter_inc = (enter_q == csbe_pkg::PressMax) ? enter_q : enter_q + 12'd1;
  assign rel_inc   = (rel_q == csbe_pkg::ReleaseMax) ? rel_q : rel_q + 13'd1;

  always_comb begin
    edit_d   = edit_q;
    sel_d    = sel_q;
    pend_d   = pend_q;
    press_d  = press_q;
    rel_d    = rel_q;
    enter_d  = enter_q;
    sec_d    = sec_q;
    min_d    = min_q;
    hour_d   = hour_q;
    day_d    = day_q;
    month_d  = month_q;
    year_d   = year_q;
    commit_d = 1'b0;

    phase_d = (phase_inc >= {1'b0, repeat_period_q}) ? 10'd0 : phase_inc[9:0];

    if (edit_q) begin
      if (pressed) begin
        rel_d   = '0;
        press_d = press_inc;
        if (press_inc >= repeat_delay_q) begin
          pend_d = sel_q;
          // Auto-increment fires when the repeat phase wraps to zero.
          if (phase_d == 10'd0) begin
            case (sel_q)
              csbe_pkg::FieldSecond: sec_d   = csbe_pkg::inc_mod60(sec_q);
              csbe_pkg::FieldMinute: min_d   = csbe_pkg::inc_mod60(min_q);
              csbe_pkg::FieldHour:   hour_d  = csbe_pkg::inc_hour(hour_q);
              csbe_pkg::FieldDay:
                day_d = csbe_pkg::inc_day(day_q, csbe_pkg::month_len(month_q, year_q));
              csbe_pkg::FieldMonth:  month_d = csbe_pkg::inc_month(month_q);
              csbe_pkg::FieldYear:   year_d  = csbe_pkg::inc_year(year_q);
              default: ;
            endcase
          end
        end else begin
          // A press released before the repeat delay moves to the next field.
          pend_d = csbe_pkg::next_select(sel_q);
        end
      end else begin
        press_d = '0;
        rel_d   = rel_inc;
        sel_d   = pend_q;
        if (rel_inc >= exit_idle_q) begin
          edit_d   = 1'b0;
          commit_d = 1'b1;
        end
      end
    end else begin
      // Idle: track the clock chip and time the entry hold.
      sec_d   = in_i.clock_second;
      min_d   = in_i.clock_minute;
      hour_d  = in_i.clock_hour;
      day_d   = in_i.clock_day;
      month_d = in_i.clock_month;
      year_d  = in_i.clock_year;
      if (pressed) begin
        enter_d = enter_inc;
        if (enter_inc >= enter_hold_q) begin
          enter_d = '0;
          edit_d  = 1'b1;
          press_d = '0;
          rel_d   = '0;
          pend_d  = sel_q;
        end
      end else begin
        enter_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edit_q      <= 1'b0;
      sel_q       <= csbe_pkg::FieldMinute;
      pend_q      <= csbe_pkg::FieldSecond;
      press_q     <= '0;
      rel_q       <= '0;
      phase_q     <= '0;
      enter_q     <= '0;
      sec_q       <= '0;
      min_q       <= '0;
      hour_q      <= '0;
      day_q       <= '0;
      month_q     <= '0;
      year_q      <= '0;
      commit_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        edit_q   <= edit_d;
        sel_q    <= sel_d;
        pend_q   <= pend_d;
        press_q  <= press_d;
        rel_q    <= rel_d;
        phase_q  <= phase_d;
        enter_q  <= enter_d;
        sec_q    <= sec_d;
        min_q    <= min_d;
        hour_q   <= hour_d;
        day_q    <= day_d;
        month_q  <= month_d;
        year_q   <= year_d;
        commit_q <= commit_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.editing        = edit_q;
  assign out_o.selected_field = sel_q;
  assign out_o.out_second     = sec_q;
  assign out_o.out_minute     = min_q;
  assign out_o.out_hour       = hour_q;
  assign out_o.out_day        = day_q;
  assign out_o.out_month      = month_q;
  assign out_o.out_year       = year_q;
  assign out_o.commit         = commit_q;

endmodule

// ===== rtl/core/csbe_checker.sv =====
// Port-level checks for the clock set-button editor, bound to the top level.
// Depends only on the top level's ports.
module csbe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       editing,
  input logic [2:0] selected_field,
  input logic       commit
);

  // A commit result always reports that edit mode has ended.
  a_commit_leaves_edit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && commit |-> !editing)
    else $error("commit shown while still editing");

  // An empty result slot never holds back the input.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty result register");

  // A tick taken while a result stalls would overwrite it.
  a_no_take_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while the result is stalled");

  // Only the six time fields can ever be selected.
  a_field_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> selected_field <= 3'd5)
    else $error("selected field out of range");

  // A stalled result holds its valid, editing, commit and selected field.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(editing) && $stable(commit)
    && $stable(selected_field))
    else $error("stalled result changed");

endmodule

bind clock_set_button_editor csbe_checker u_csbe_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid       (in_i.valid),
  .in_ready       (in_i.ready),
  .out_valid      (out_o.valid),
  .out_ready      (out_o.ready),
  .editing        (out_o.editing),
  .selected_field (out_o.selected_field),
  .commit         (out_o.commit)
);

// ===== dv/tb_clock_set_button_editor.sv =====
// Self-checking testbench for the clock set-button editor: timer ticks go in through the
// tick stream and each result is checked against a cycle-free model of the edit logic.
// Depends on csbe_pkg, the stream interfaces in csbe_if and the clock_set_button_editor RTL.
module tb_clock_set_button_editor;

  // A run of cycles with no transfer on either stream longer than this is a hang.
  localparam int unsigned StallLimit = 4000;

  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hour;
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year;
  } clock_time_t;

  // Everything the block shows after one tick.
  typedef struct packed {
    logic        editing;
    logic [2:0]  field;
    clock_time_t shown;
    logic        commit;
  } clock_view_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we;
  logic [1:0]                    cfg_idx;
  logic [csbe_pkg::CfgDataW-1:0] cfg_wdata;

  csbe_in_if  in_if ();
  csbe_out_if out_if ();

  clock_set_button_editor dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // Settings as the block holds them; they follow every register write.
  logic [11:0] cfg_enter;
  logic [11:0] cfg_delay;
  logic [9:0]  cfg_period;
  logic [12:0] cfg_exit;

  // Shadow of the edit state.
  logic        edit_on;
  logic [2:0]  sel_field;
  logic [2:0]  pending_field;
  logic [11:0] press_run;
  logic [12:0] release_run;
  logic [9:0]  step_phase;
  logic [11:0] arm_run;
  clock_time_t held_time;

  // Views predicted for accepted ticks, oldest first.
  clock_view_t expected_views[$];

  int unsigned ticks_sent;
  int unsigned results_checked;
  int unsigned commits_seen;
  int unsigned edit_entries;
  int unsigned mismatches;
  int unsigned burst_left;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Works out the view after one tick and moves the shadow state along with it.
  // The repeat phase runs on every tick, whether or not the editor is active.
  function automatic clock_view_t advance_editor(input logic pressed, input clock_time_t t);
    clock_view_t v;
    logic [10:0] phase_up;
    logic        commit_now;
    int          len;
    int          nxt;
    commit_now = 1'b0;
    phase_up = {1'b0, step_phase} + 11'd1;
    step_phase = (phase_up >= {1'b0, cfg_period}) ? 10'd0 : phase_up[9:0];
    if (edit_on) begin
      if (pressed) begin
        release_run = '0;
        if (!(&press_run)) press_run = press_run + 12'd1;
        if (press_run >= cfg_delay) begin
          // A long hold steps the selected field each time the phase wraps.
          if (step_phase == 10'd0) begin
            case (sel_field)
              csbe_pkg::FieldSecond: held_time.sec = 6'((held_time.sec + 1) % 60);
              csbe_pkg::FieldMinute: held_time.min = 6'((held_time.min + 1) % 60);
              csbe_pkg::FieldHour:   held_time.hour = 5'((held_time.hour + 1) % 24);
              csbe_pkg::FieldDay: begin
                len = 31;
                if (held_time.month == 4'd4 || held_time.month == 4'd6 ||
                    held_time.month == 4'd9 || held_time.month == 4'd11) begin
                  len = 30;
                end else if (held_time.month == 4'd2) begin
                  len = (held_time.year == 7'd20 || held_time.year == 7'd24 ||
                         held_time.year == 7'd28) ? 29 : 28;
                end
                // Days past the month length fold over; zero stands for the last day.
                nxt = (held_time.day + 1) % len;
                held_time.day = 5'((nxt == 0) ? len : nxt);
              end
              csbe_pkg::FieldMonth: begin
                nxt = (held_time.month + 1) % 12;
                held_time.month = 4'((nxt == 0) ? 12 : nxt);
              end
              csbe_pkg::FieldYear: begin
                if (held_time.year >= 7'd20 && held_time.year <= 7'd30) begin
                  held_time.year = 7'((held_time.year - 20 + 1) % 11 + 20);
                end else begin
                  held_time.year = 7'd20;
                end
              end
              default: ;
            endcase
          end
          pending_field = sel_field;
        end else begin
          // A press still short of the repeat delay proposes the next field.
          pending_field = 3'((sel_field + 1) % 6);
        end
      end else begin
        press_run = '0;
        if (!(&release_run)) release_run = release_run + 13'd1;
        sel_field = pending_field;
        if (release_run >= cfg_exit) begin
          edit_on = 1'b0;
          commit_now = 1'b1;
        end
      end
    end else begin
      held_time = t;
      if (pressed) begin
        if (!(&arm_run)) arm_run = arm_run + 12'd1;
        if (arm_run >= cfg_enter) begin
          arm_run = '0;
          edit_on = 1'b1;
          press_run = '0;
          release_run = '0;
          pending_field = sel_field;
          edit_entries++;
        end
      end else begin
        arm_run = '0;
      end
    end
    v.editing = edit_on;
    v.field = sel_field;
    v.shown = held_time;
    v.commit = commit_now;
    return v;
  endfunction

  function automatic clock_time_t mk_time(input int s, input int mi, input int h,
                                          input int d, input int mo, input int y);
    clock_time_t t;
    t.sec = 6'(s);
    t.min = 6'(mi);
    t.hour = 5'(h);
    t.day = 5'(d);
    t.month = 4'(mo);
    t.year = 7'(y);
    return t;
  endfunction

  // Random clock chip time. Years lean toward the 20..30 edit range so that the
  // year wrap gets exercised, and now and then the month is out of range.
  function automatic clock_time_t random_time();
    clock_time_t t;
    int          mo;
    mo = $urandom_range(1, 12);
    if ($urandom_range(0, 15) == 0) begin
      mo = $urandom_range(12, 15);
      if (mo == 12) mo = 0;
    end
    t = mk_time($urandom_range(0, 59), $urandom_range(0, 59), $urandom_range(0, 23),
                $urandom_range(1, 31), mo,
                $urandom_range(0, 1) ? $urandom_range(18, 32) : $urandom_range(0, 99));
    return t;
  endfunction

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatches++;
    $display("mismatch in %s at result %0d: got %0d, expected %0d", what,
             results_checked, got, want);
  endtask

  // Sends one tick. The sender works in bursts; between bursts valid drops for a
  // random number of cycles, and about a third of the bursts follow with no gap.
  // The view is predicted at the edge where the transfer happens.
  task automatic send_tick(input logic pressed, input clock_time_t t);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        @(negedge clk_i);
        in_if.valid = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    @(negedge clk_i);
    in_if.valid = 1'b1;
    in_if.button_pressed = pressed;
    in_if.clock_second = t.sec;
    in_if.clock_minute = t.min;
    in_if.clock_hour = t.hour;
    in_if.clock_day = t.day;
    in_if.clock_month = t.month;
    in_if.clock_year = t.year;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    expected_views.push_back(advance_editor(pressed, t));
    ticks_sent++;
  endtask

  // The clock inputs only matter while the editor is idle, so they stay random.
  task automatic hold_button(input logic level, input int unsigned n);
    repeat (n) send_tick(level, random_time());
  endtask

  // Drops valid and waits until every predicted view has been transferred, then a
  // few more cycles so that nothing is left in flight.
  task automatic settle_editor();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (expected_views.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input csbe_pkg::cfg_idx_e idx, input int unsigned value);
    @(negedge clk_i);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = value[csbe_pkg::CfgDataW-1:0];
    @(negedge clk_i);
    cfg_we = 1'b0;
    case (idx)
      csbe_pkg::CfgEnterHold:    cfg_enter = value[11:0];
      csbe_pkg::CfgRepeatDelay:  cfg_delay = value[11:0];
      csbe_pkg::CfgRepeatPeriod: cfg_period = value[9:0];
      csbe_pkg::CfgExitIdle:     cfg_exit = value[12:0];
      default: ;
    endcase
  endtask

  // Settings change only once the block has gone quiet.
  task automatic write_config(input int unsigned enter_v, input int unsigned delay_v,
                              input int unsigned period_v, input int unsigned exit_v);
    settle_editor();
    write_reg(csbe_pkg::CfgEnterHold, enter_v);
    write_reg(csbe_pkg::CfgRepeatDelay, delay_v);
    write_reg(csbe_pkg::CfgRepeatPeriod, period_v);
    write_reg(csbe_pkg::CfgExitIdle, exit_v);
  endtask

  // One edit session under the current settings: a little idle noise, a hold long
  // enough to enter edit mode, a random mix of taps, long holds and noise, and a
  // release long enough to leave edit mode with a commit.
  task automatic run_session();
    int unsigned ops;
    int unsigned kind;
    int unsigned n;
    repeat ($urandom_range(0, 4)) send_tick(1'($urandom_range(0, 1)), random_time());
    hold_button(1'b1, (cfg_enter == 0) ? 1 : cfg_enter);
    ops = $urandom_range(1, 8);
    repeat (ops) begin
      kind = $urandom_range(0, 5);
      if (kind == 5) begin
        repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(0, 1)), random_time());
      end else begin
        if (kind < 2) begin
          n = (cfg_delay > 1) ? $urandom_range(1, cfg_delay - 1) : 1;
        end else begin
          n = ((cfg_delay == 0) ? 1 : cfg_delay) + $urandom_range(0, 2 * cfg_period + 2);
        end
        hold_button(1'b1, n);
        hold_button(1'b0, (cfg_exit > 1) ? $urandom_range(1, cfg_exit - 1) : 1);
      end
    end
    hold_button(1'b0, (cfg_exit == 0) ? 1 : cfg_exit);
  endtask

  // Reset settings: the times follow the clock chip, and a hold far shorter than
  // the 800-tick entry threshold leaves the editor idle.
  task automatic test_reset_settings();
    hold_button(1'b0, 6);
    hold_button(1'b1, 40);
    hold_button(1'b0, 4);
  endtask

  // Short directed walk with a zero enter threshold and a phase that is zero on
  // every tick: extremes of the clock inputs, then a long hold on each field from
  // minute to year with a tap in between, covering the minute, hour and year wraps
  // and a day past the end of April.
  task automatic test_field_walk();
    write_config(0, 2, 0, 2);
    send_tick(1'b0, mk_time(0, 0, 0, 1, 1, 0));
    send_tick(1'b0, mk_time(59, 59, 23, 31, 12, 99));
    send_tick(1'b1, mk_time(59, 59, 23, 31, 4, 30));
    repeat (4) begin
      hold_button(1'b1, 2);
      hold_button(1'b0, 1);
      hold_button(1'b1, 1);
      hold_button(1'b0, 1);
    end
    hold_button(1'b1, 2);
    hold_button(1'b0, 2);
  endtask

  // Largest settings with a hold and a release far short of them, then the
  // smallest ones and all zeros.
  task automatic test_extreme_settings();
    write_config(4095, 4095, 1023, 8191);
    hold_button(1'b0, 3);
    hold_button(1'b1, 40);
    hold_button(1'b0, 3);
    write_config(1, 1, 1, 1);
    repeat (2) run_session();
    write_config(0, 0, 0, 0);
    repeat (2) run_session();
  endtask

  // Random sessions under small random settings, changed every couple of hundred ticks.
  task automatic test_random_sessions();
    int unsigned start_ticks;
    int unsigned phase_start;
    start_ticks = ticks_sent;
    phase_start = ticks_sent;
    write_config($urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(0, 5),
                 $urandom_range(0, 8));
    while (ticks_sent - start_ticks < 550) begin
      if (ticks_sent - phase_start >= 200) begin
        write_config($urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(0, 5),
                     $urandom_range(0, 8));
        phase_start = ticks_sent;
      end
      run_session();
    end
  endtask

  // Receiver stalls: for a random stretch of cycles at a time, one mode is picked from
  // always ready, coin flips, a rotating bit pattern and mostly ready.
  initial begin : sink_stall
    int unsigned mode;
    int unsigned left;
    logic [31:0] pat;
    mode = 0;
    left = 0;
    pat = '1;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(32, 256);
        pat = $urandom | 32'h1;
      end
      left--;
      case (mode)
        0: out_if.ready = 1'b1;
        1: out_if.ready = 1'($urandom_range(0, 1));
        2: begin
          out_if.ready = pat[0];
          pat = {pat[0], pat[31:1]};
        end
        default: out_if.ready = ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Each transferred result is checked field by field against the oldest prediction.
  always @(posedge clk_i) begin
    clock_view_t want;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (expected_views.size() == 0) begin
        report_mismatch("result with nothing expected", 16'd1, 16'd0);
      end else begin
        want = expected_views.pop_front();
        if (out_if.editing !== want.editing)
          report_mismatch("editing", 16'(out_if.editing), 16'(want.editing));
        if (out_if.selected_field !== want.field)
          report_mismatch("selected_field", 16'(out_if.selected_field), 16'(want.field));
        if (out_if.out_second !== want.shown.sec)
          report_mismatch("out_second", 16'(out_if.out_second), 16'(want.shown.sec));
        if (out_if.out_minute !== want.shown.min)
          report_mismatch("out_minute", 16'(out_if.out_minute), 16'(want.shown.min));
        if (out_if.out_hour !== want.shown.hour)
          report_mismatch("out_hour", 16'(out_if.out_hour), 16'(want.shown.hour));
        if (out_if.out_day !== want.shown.day)
          report_mismatch("out_day", 16'(out_if.out_day), 16'(want.shown.day));
        if (out_if.out_month !== want.shown.month)
          report_mismatch("out_month", 16'(out_if.out_month), 16'(want.shown.month));
        if (out_if.out_year !== want.shown.year)
          report_mismatch("out_year", 16'(out_if.out_year), 16'(want.shown.year));
        if (out_if.commit !== want.commit)
          report_mismatch("commit", 16'(out_if.commit), 16'(want.commit));
        if (want.commit) commits_seen++;
      end
      results_checked++;
    end
  end

  // Ends a run that hangs: too many cycles in a row without any transfer.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
          (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("timeout: no transfer for %0d cycles", StallLimit);
    $display("tb_clock_set_button_editor: FAIL");
    $finish;
  end

  initial begin
    // Every input is known from time zero, with reset held.
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.button_pressed = 1'b0;
    in_if.clock_second = '0;
    in_if.clock_minute = '0;
    in_if.clock_hour = '0;
    in_if.clock_day = '0;
    in_if.clock_month = '0;
    in_if.clock_year = '0;

    // Shadow state starts from the reset values of the block.
    cfg_enter = 12'd800;
    cfg_delay = 12'd600;
    cfg_period = 10'd200;
    cfg_exit = 13'd3000;
    edit_on = 1'b0;
    sel_field = csbe_pkg::FieldMinute;
    pending_field = csbe_pkg::FieldSecond;
    press_run = '0;
    release_run = '0;
    step_phase = '0;
    arm_run = '0;
    held_time = '0;
    ticks_sent = 0;
    results_checked = 0;
    commits_seen = 0;
    edit_entries = 0;
    mismatches = 0;
    burst_left = 0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_settings();
    test_field_walk();
    test_extreme_settings();
    test_random_sessions();

    settle_editor();
    repeat (8) @(posedge clk_i);
    if (expected_views.size() != 0) begin
      report_mismatch("results never transferred", 16'(expected_views.size()), 16'd0);
    end

    $display("summary: %0d ticks sent, %0d results checked, %0d mismatches", ticks_sent,
             results_checked, mismatches);
    $display("summary: %0d entries into edit mode, %0d commits, %s", edit_entries,
             commits_seen, "default, extreme and random settings");
    if (mismatches == 0) begin
      $display("tb_clock_set_button_editor: PASS");
    end else begin
      $display("tb_clock_set_button_editor: FAIL");
    end
    $finish;
  end

endmodule

// ===== clock_set_button_editor.f =====
rtl/core/csbe_pkg.sv
rtl/core/csbe_if.sv
rtl/core/clock_set_button_editor.sv
rtl/core/csbe_checker.sv
dv/tb_clock_set_button_editor.sv
